// ===== rtl/rhpf_pkg.sv =====
// shared types, constants and the kernel sum for the rgb high-pass filter
package rhpf_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   localparam int WIDTH_REG_W    = 12;
   localparam int HEIGHT_REG_W   = 13;
   localparam int STRENGTH_W     = 8;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRENGTH_TENTHS = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH    = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT   = 13'd480;
   localparam logic [STRENGTH_W-1:0]   RESET_STRENGTH = 8'd10;

   localparam int SUM_W  = 13;
   localparam int MAG_W  = 12;
   localparam int PROD_W = 20;

   // gain products at or above this give 255 after the divide by ten
   localparam logic [PROD_W-1:0] SAT_LIMIT   = 20'd2560;
   // ceil(2^15 / 10), exact for products below the saturation limit
   localparam logic [MAG_W-1:0]  RECIP_TEN   = 12'd3277;
   localparam int                RECIP_SHIFT = 15;

   typedef logic [23:0] pixel_type;

   // [row][column], column 2 is the newest
   typedef logic [2:0][2:0][23:0] window_type;
   typedef logic [2:0][2:0]       mask_type;

   typedef struct packed {
      pixel_type prev;
      pixel_type cur;
   } line_entry_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] red;
      logic signed [SUM_W-1:0] green;
      logic signed [SUM_W-1:0] blue;
      logic                    last;
   } sums_type;

   localparam logic signed [SUM_W-1:0] KERNEL_WEIGHT [3][3] = '{
      '{-13'sd1, -13'sd2, -13'sd1},
      '{-13'sd2,  13'sd12, -13'sd2},
      '{-13'sd1, -13'sd2, -13'sd1}
   };

   // masked 3x3 kernel sum of one channel, lsb picks the channel byte
   function automatic logic signed [SUM_W-1:0] kernel_sum(input window_type win,
                                                          input mask_type use_mask,
                                                          input int unsigned lsb);
      logic signed [SUM_W-1:0] acc;
      logic [7:0]              p;
      acc = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p = win[r][c][lsb +: 8];
            if (use_mask[r][c]) begin
               acc = acc + KERNEL_WEIGHT[r][c] * $signed({5'd0, p});
            end
         end
      end
      return acc;
   endfunction

endpackage

// ===== rtl/rhpf_line_store.sv =====
// two-row line store, one entry per column, one read and one write port
module rhpf_line_store #(
   parameter  int DEPTH  = rhpf_pkg::DEFAULT_MAX_WIDTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output rhpf_pkg::line_entry_type rd_data,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  rhpf_pkg::line_entry_type wr_data
);

   rhpf_pkg::line_entry_type store_ff [DEPTH];
   rhpf_pkg::line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rhpf_window.sv =====
// 3x3 window, output position tracking and masked kernel sums
module rhpf_window #(
   parameter  int MAX_WIDTH  = rhpf_pkg::DEFAULT_MAX_WIDTH,
   parameter  int MAX_HEIGHT = rhpf_pkg::DEFAULT_MAX_HEIGHT,
   localparam int COL_W      = $clog2(MAX_WIDTH),
   localparam int WID_W      = $clog2(MAX_WIDTH + 1),
   localparam int ROW_W      = $clog2(MAX_HEIGHT + 2)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                s1_valid,
   input  logic                s1_emit,
   output logic                s1_ready,
   input  rhpf_pkg::pixel_type col_top,
   input  rhpf_pkg::pixel_type col_mid,
   input  rhpf_pkg::pixel_type col_pix,
   input  logic [WID_W-1:0]    img_width,
   input  logic [ROW_W-1:0]    img_height,
   output logic                s2_valid,
   output rhpf_pkg::sums_type  s2_data,
   input  logic                s2_ready
);

   rhpf_pkg::window_type window_ff, window_in, win_shift;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [ROW_W-1:0]     out_row_ff, out_row_in;
   logic                 s2_valid_ff, s2_valid_in;
   rhpf_pkg::sums_type   s2_data_ff, s2_data_in;
   rhpf_pkg::mask_type   use_mask;
   logic [2:0]           row_ok, col_ok;
   logic                 col_right, row_bottom, last, advance;

   always_comb begin
      col_right  = (WID_W'(out_col_ff) + WID_W'(1)) >= img_width;
      row_bottom = (out_row_ff + ROW_W'(1)) >= img_height;
      last       = col_right && row_bottom;

      row_ok = {!row_bottom, 1'b1, out_row_ff != '0};
      col_ok = {!col_right, 1'b1, out_col_ff != '0};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            use_mask[r][c] = row_ok[r] && col_ok[c];
         end
      end

      for (int r = 0; r < 3; r++) begin
         win_shift[r][0] = window_ff[r][1];
         win_shift[r][1] = window_ff[r][2];
      end
      win_shift[0][2] = col_top;
      win_shift[1][2] = col_mid;
      win_shift[2][2] = col_pix;

      // an item that gives no result never waits on the sum stage
      s1_ready = !s1_emit || !s2_valid_ff || s2_ready;
      advance  = s1_valid && s1_ready;

      window_in   = window_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      s2_valid_in = s2_valid_ff && !s2_ready;
      s2_data_in  = s2_data_ff;

      if (advance) begin
         window_in = win_shift;
         if (s1_emit) begin
            s2_valid_in      = 1'b1;
            s2_data_in.red   = rhpf_pkg::kernel_sum(win_shift, use_mask, 16);
            s2_data_in.green = rhpf_pkg::kernel_sum(win_shift, use_mask, 8);
            s2_data_in.blue  = rhpf_pkg::kernel_sum(win_shift, use_mask, 0);
            s2_data_in.last  = last;
            priority if (last) begin
               window_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (col_right) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end

      if (clear) begin
         window_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         window_ff   <= window_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_data_ff <= s2_data_in;
   end

   assign s2_valid = s2_valid_ff;
   assign s2_data  = s2_data_ff;

endmodule

// ===== rtl/rhpf_scale.sv =====
// gain multiply, divide by ten and saturation, ending in the output register
module rhpf_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                s2_valid,
   input  rhpf_pkg::sums_type                  s2_data,
   output logic                                s2_ready,
   input  logic [rhpf_pkg::STRENGTH_W-1:0]     strength,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_red_out,
   output logic [7:0]                          rsp_green_out,
   output logic [7:0]                          rsp_blue_out,
   output logic                                rsp_frame_done
);

   logic signed [rhpf_pkg::SUM_W-1:0] sum_ch [3];
   logic [rhpf_pkg::MAG_W-1:0]        mag [3];
   logic [rhpf_pkg::PROD_W-1:0]       prod_ff [3], prod_in [3];
   logic [2*rhpf_pkg::MAG_W-1:0]      quot_wide [3];
   logic [7:0]                        chan_ff [3], chan_in [3];
   logic                              s3_valid_ff, s3_valid_in;
   logic                              s3_last_ff, s3_last_in;
   logic                              out_valid_ff, out_valid_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_free, s3_free;

   always_comb begin
      sum_ch[0] = s2_data.red;
      sum_ch[1] = s2_data.green;
      sum_ch[2] = s2_data.blue;

      out_free = !out_valid_ff || rsp_ready;
      s3_free  = !s3_valid_ff || out_free;
      s2_ready = s3_free;

      s3_valid_in  = s3_free ? s2_valid : s3_valid_ff;
      s3_last_in   = s3_last_ff;
      out_valid_in = out_free ? s3_valid_ff : out_valid_ff;
      out_last_in  = out_last_ff;

      for (int i = 0; i < 3; i++) begin
         // a sum at or below zero truncates to a result of zero
         mag[i] = (sum_ch[i] > $signed(rhpf_pkg::SUM_W'(0))) ?
                  sum_ch[i][rhpf_pkg::MAG_W-1:0] : '0;
         prod_in[i] = prod_ff[i];
         if (s2_valid && s3_free) begin
            prod_in[i] = {{(rhpf_pkg::PROD_W-rhpf_pkg::STRENGTH_W){1'b0}}, strength} *
                         {{(rhpf_pkg::PROD_W-rhpf_pkg::MAG_W){1'b0}}, mag[i]};
         end

         quot_wide[i] = {{rhpf_pkg::MAG_W{1'b0}}, prod_ff[i][rhpf_pkg::MAG_W-1:0]} *
                        {{rhpf_pkg::MAG_W{1'b0}}, rhpf_pkg::RECIP_TEN};
         chan_in[i] = chan_ff[i];
         if (s3_valid_ff && out_free) begin
            chan_in[i] = (prod_ff[i] >= rhpf_pkg::SAT_LIMIT) ? 8'hFF :
                         quot_wide[i][rhpf_pkg::RECIP_SHIFT +: 8];
         end
      end

      if (s2_valid && s3_free) begin
         s3_last_in = s2_data.last;
      end
      if (s3_valid_ff && out_free) begin
         out_last_in = s3_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_last_ff  <= s3_last_in;
      out_last_ff <= out_last_in;
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= prod_in[i];
         chan_ff[i] <= chan_in[i];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_red_out    = chan_ff[0];
   assign rsp_green_out  = chan_ff[1];
   assign rsp_blue_out   = chan_ff[2];
   assign rsp_frame_done = out_last_ff;

endmodule

// ===== rtl/rgb_high_pass_3x3_filter_core.sv =====
// rgb 3x3 high-pass filter core: registers, input tracking and pipeline top
//
//   channel  ports                     moves
//   req      req_valid / req_ready     one pixel or drain word
//   rsp      rsp_valid / rsp_ready     one filtered pixel word
//   csr      csr_write_enable          one register write, no wait
//
// one word per cycle unless rsp_ready stalls; the line store read of a column and
// the write-back of the word ahead share a cycle, so the input side sustains a
// word every clock. a result passes the s1, sum, product and output registers after
// the word completing its window, which is image_width+1 words after the pixel.
// reset is synchronous and clears control state only; the line store is not
// cleared, entries from before the current frame are masked as off-frame.
// rsp_ready low fills the sum, product and output stages, then holds req_ready low.
module rgb_high_pass_3x3_filter_core #(
   parameter  int MAX_WIDTH  = rhpf_pkg::DEFAULT_MAX_WIDTH,
   parameter  int MAX_HEIGHT = rhpf_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [7:0]                         req_red_in,
   input  logic [7:0]                         req_green_in,
   input  logic [7:0]                         req_blue_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_red_out,
   output logic [7:0]                         rsp_green_out,
   output logic [7:0]                         rsp_blue_out,
   output logic                               rsp_frame_done,
   input  logic                               csr_write_enable,
   input  logic [rhpf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rhpf_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

   logic [rhpf_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [rhpf_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [rhpf_pkg::STRENGTH_W-1:0]   strength_ff, strength_in;
   logic [COL_W-1:0]                  in_col_ff, in_col_in;
   logic [ROW_W-1:0]                  in_row_ff, in_row_in;
   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_emit_ff, s1_emit_in;
   rhpf_pkg::pixel_type               s1_pix_ff, s1_pix_in;
   logic [COL_W-1:0]                  s1_addr_ff, s1_addr_in;

   logic [31:0]              width_wide, height_wide;
   logic [WID_W-1:0]         img_width;
   logic [ROW_W-1:0]         img_height;
   logic                     restart, rows_done, accept, enter, emit, frame_end;
   logic                     win_s1_ready, s1_go;
   rhpf_pkg::line_entry_type rd_data, wr_data;
   logic                     s2_valid, s2_ready;
   rhpf_pkg::sums_type       s2_data;

   always_comb begin
      width_wide  = 32'(width_ff);
      height_wide = 32'(height_ff);
      priority if (width_wide < 32'd2) begin
         img_width = WID_W'(2);
      end else if (width_wide > 32'(MAX_WIDTH)) begin
         img_width = WID_W'(MAX_WIDTH);
      end else begin
         img_width = WID_W'(width_wide);
      end
      priority if (height_wide < 32'd2) begin
         img_height = ROW_W'(2);
      end else if (height_wide > 32'(MAX_HEIGHT)) begin
         img_height = ROW_W'(MAX_HEIGHT);
      end else begin
         img_height = ROW_W'(height_wide);
      end

      restart = csr_write_enable && ((csr_index == rhpf_pkg::CSR_IMAGE_WIDTH) ||
                                     (csr_index == rhpf_pkg::CSR_IMAGE_HEIGHT));

      rows_done = in_row_ff >= img_height;
      s1_go     = s1_valid_ff && win_s1_ready;
      req_ready = !s1_valid_ff || s1_go;
      accept    = req_valid && req_ready;
      // drain words before the frame is fully in are dropped
      enter     = accept && !(req_mode && !rows_done);
      emit      = (in_row_ff >= ROW_W'(2)) || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      // the word that completes the last result ends the frame and resets the position
      frame_end = (in_row_ff == (img_height + ROW_W'(1))) && (in_col_ff == '0);

      width_in    = width_ff;
      height_in   = height_ff;
      strength_in = strength_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rhpf_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_data[rhpf_pkg::WIDTH_REG_W-1:0];
            end
            rhpf_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_data[rhpf_pkg::HEIGHT_REG_W-1:0];
            end
            rhpf_pkg::CSR_STRENGTH_TENTHS: begin
               strength_in = csr_data[rhpf_pkg::STRENGTH_W-1:0];
            end
            default: begin
            end
         endcase
      end

      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      s1_valid_in = enter ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s1_emit_in  = s1_emit_ff;
      s1_pix_in   = s1_pix_ff;
      s1_addr_in  = s1_addr_ff;
      if (enter) begin
         s1_emit_in = emit;
         s1_pix_in  = (req_mode || rows_done) ? '0 :
                      {req_red_in, req_green_in, req_blue_in};
         s1_addr_in = in_col_ff;
         priority if (frame_end) begin
            in_col_in = '0;
            in_row_in = '0;
         end else if ((WID_W'(in_col_ff) + WID_W'(1)) >= img_width) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
      if (restart) begin
         in_col_in = '0;
         in_row_in = '0;
      end

      // the row above moves up, the new pixel becomes the row below
      wr_data.prev = rd_data.cur;
      wr_data.cur  = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= rhpf_pkg::RESET_WIDTH;
         height_ff   <= rhpf_pkg::RESET_HEIGHT;
         strength_ff <= rhpf_pkg::RESET_STRENGTH;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         strength_ff <= strength_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_emit_ff <= s1_emit_in;
      s1_pix_ff  <= s1_pix_in;
      s1_addr_ff <= s1_addr_in;
   end

   rhpf_line_store #(
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (enter),
      .rd_addr (in_col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data)
   );

   rhpf_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .clear      (restart),
      .s1_valid   (s1_valid_ff),
      .s1_emit    (s1_emit_ff),
      .s1_ready   (win_s1_ready),
      .col_top    (rd_data.prev),
      .col_mid    (rd_data.cur),
      .col_pix    (s1_pix_ff),
      .img_width  (img_width),
      .img_height (img_height),
      .s2_valid   (s2_valid),
      .s2_data    (s2_data),
      .s2_ready   (s2_ready)
   );

   rhpf_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .s2_valid       (s2_valid),
      .s2_data        (s2_data),
      .s2_ready       (s2_ready),
      .strength       (strength_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

// ===== verif/rgb_high_pass_3x3_filter_core_tb.sv =====
// testbench for the rgb high-pass 3x3 filter core, checked word by word against a filter predictor
module rgb_high_pass_3x3_filter_core_tb;

   localparam logic [rhpf_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;
   localparam int MAX_W = rhpf_pkg::DEFAULT_MAX_WIDTH;
   localparam int MAX_H = rhpf_pkg::DEFAULT_MAX_HEIGHT;
   // results still pass the pipeline registers after the completing word, leave some margin
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_WORDS = 300;
   // words sent into each of the largest frames before the next size write drops it
   localparam int LARGE_FRAME_WORDS = 24;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       done;
   } filtered_px_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_mode;
   logic [7:0]                       req_red_in;
   logic [7:0]                       req_green_in;
   logic [7:0]                       req_blue_in;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [7:0]                       rsp_red_out;
   logic [7:0]                       rsp_green_out;
   logic [7:0]                       rsp_blue_out;
   logic                             rsp_frame_done;
   logic                             csr_write_enable;
   logic [rhpf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rhpf_pkg::CSR_DATA_W-1:0]  csr_data;

   rgb_high_pass_3x3_filter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_frame_done   (rsp_frame_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [rhpf_pkg::WIDTH_REG_W-1:0]  cfg_width;
   logic [rhpf_pkg::HEIGHT_REG_W-1:0] cfg_height;
   logic [rhpf_pkg::STRENGTH_W-1:0]   cfg_strength;
   rhpf_pkg::pixel_type               upper_line [MAX_W];
   rhpf_pkg::pixel_type               middle_line [MAX_W];
   rhpf_pkg::pixel_type               window_px [3][3];
   int unsigned                       in_col, in_row, out_col, out_row;

   filtered_px_type expected_pixels [$];
   int unsigned  mismatches = 0;
   int unsigned  words_taken = 0;
   int unsigned  req_gap_max = 0;
   int unsigned  rsp_gap_max = 0;
   int unsigned  rsp_stall = 0;

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_frame_model();
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            window_px[r][c] = '0;
         end
      end
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic logic [7:0] filter_channel_model(bit use_px [3][3], int lsb);
      int sum;
      int weight;
      int scaled;
      sum = 0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (use_px[r][c]) begin
               if (r == 1 && c == 1) weight = 12;
               else if (r == 1 || c == 1) weight = -2;
               else weight = -1;
               sum += weight * int'(window_px[r][c][lsb +: 8]);
            end
         end
      end
      // int divide truncates toward zero
      scaled = (int'(cfg_strength) * sum) / 10;
      if (scaled < 0) return 8'd0;
      if (scaled > 255) return 8'd255;
      return scaled[7:0];
   endfunction

   // steps the predictor by one accepted word, returns 0 when the word is ignored
   function automatic bit advance_filter(logic mode, logic [7:0] red, logic [7:0] green,
                                         logic [7:0] blue);
      int unsigned         w, h, x;
      rhpf_pkg::pixel_type pix, top, mid;
      bit                  emit, is_last;
      bit                  use_px [3][3];
      filtered_px_type     res;
      w = clamp_size(cfg_width, MAX_W);
      h = clamp_size(cfg_height, MAX_H);
      if (mode == MODE_DRAIN && in_row < h) return 1'b0;
      pix = (mode == MODE_PIXEL && in_row < h) ? {red, green, blue} : '0;
      if (in_col >= w) in_col = 0;
      x = in_col;
      top = upper_line[x];
      mid = middle_line[x];
      upper_line[x] = mid;
      middle_line[x] = pix;
      for (int r = 0; r < 3; r++) begin
         window_px[r][0] = window_px[r][1];
         window_px[r][1] = window_px[r][2];
      end
      window_px[0][2] = top;
      window_px[1][2] = mid;
      window_px[2][2] = pix;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return 1'b1;
      // off-frame neighbors count as zero
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            use_px[r][c] = !((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
                             (c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w));
         end
      end
      is_last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.red = filter_channel_model(use_px, 16);
      res.green = filter_channel_model(use_px, 8);
      res.blue = filter_channel_model(use_px, 0);
      res.done = is_last;
      expected_pixels.push_back(res);
      if (is_last) begin
         restart_frame_model();
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // result side: compare each word, then stall a random number of cycles
   always @(posedge clock) begin
      filtered_px_type want;
      int unsigned     stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result word: red_out %0d green_out %0d blue_out %0d",
                   rsp_red_out, rsp_green_out, rsp_blue_out);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("red_out", want.red, rsp_red_out);
            check_field("green_out", want.green, rsp_green_out);
            check_field("blue_out", want.blue, rsp_blue_out);
            check_field("frame_done", 8'(want.done), 8'(rsp_frame_done));
         end
         stall = $urandom_range(0, rsp_gap_max);
         rsp_ready <= (stall == 0);
         rsp_stall <= stall;
      end else begin
         if (rsp_stall > 0) rsp_stall <= rsp_stall - 1;
         rsp_ready <= (rsp_stall <= 1);
      end
   end

   // valid stays high after acceptance unless the next word waits
   task automatic send_word(logic mode, logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_red_in <= red;
      req_green_in <= green;
      req_blue_in <= blue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (advance_filter(mode, red, green, blue)) words_taken++;
   endtask

   task automatic send_pixel();
      send_word(MODE_PIXEL, pick_byte(), pick_byte(), pick_byte());
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (expected_pixels.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [rhpf_pkg::CSR_INDEX_W-1:0] idx,
                            logic [rhpf_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         rhpf_pkg::CSR_IMAGE_WIDTH: begin
            cfg_width = value[rhpf_pkg::WIDTH_REG_W-1:0];
            restart_frame_model();
         end
         rhpf_pkg::CSR_IMAGE_HEIGHT: begin
            cfg_height = value[rhpf_pkg::HEIGHT_REG_W-1:0];
            restart_frame_model();
         end
         rhpf_pkg::CSR_STRENGTH_TENTHS: cfg_strength = value[rhpf_pkg::STRENGTH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_frame(int unsigned w, int unsigned h);
      write_reg(rhpf_pkg::CSR_IMAGE_WIDTH, rhpf_pkg::CSR_DATA_W'(w));
      write_reg(rhpf_pkg::CSR_IMAGE_HEIGHT, rhpf_pkg::CSR_DATA_W'(h));
   endtask

   // tail of the frame: drains, some of them pixels that act as drains
   task automatic flush_frame();
      int unsigned w;
      w = clamp_size(cfg_width, MAX_W);
      repeat (w + 1) begin
         if ($urandom_range(0, 3) == 0) send_pixel();
         else send_word(MODE_DRAIN, pick_byte(), pick_byte(), pick_byte());
      end
   endtask

   // n pixels of the current frame, with stray drains that arrive too early
   task automatic send_pixels(int unsigned n);
      repeat (n) begin
         if ($urandom_range(0, 15) == 0) begin
            send_word(MODE_DRAIN, pick_byte(), pick_byte(), pick_byte());
         end
         send_pixel();
      end
   endtask

   task automatic pick_idling();
      case ($urandom_range(0, 3))
         0: begin req_gap_max = 0;  rsp_gap_max = 0;  end
         1: begin req_gap_max = 18; rsp_gap_max = 0;  end
         2: begin req_gap_max = 0;  rsp_gap_max = 18; end
         default: begin req_gap_max = 18; rsp_gap_max = 18; end
      endcase
   endtask

   // impulse in red, inverted impulse in green, checkerboard in blue on a 3x3 frame, default gain
   task automatic test_kernel_extremes();
      bit centre;
      set_frame(3, 3);
      send_word(MODE_DRAIN, 8'hff, 8'hff, 8'hff);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            centre = (r == 1 && c == 1);
            send_word(MODE_PIXEL, centre ? 8'hff : 8'h00, centre ? 8'h00 : 8'hff,
                      ((r + c) % 2) ? 8'hff : 8'h00);
            if (r == 1 && c == 0) send_word(MODE_DRAIN, 8'h00, 8'h00, 8'h00);
         end
      end
      send_word(MODE_PIXEL, 8'hff, 8'hff, 8'hff);
      repeat (3) send_word(MODE_DRAIN, 8'h00, 8'h00, 8'h00);
      wait_quiet();
   endtask

   task automatic test_strength_extremes();
      logic [rhpf_pkg::STRENGTH_W-1:0] gains [3];
      gains = '{8'd0, 8'd255, 8'd1};
      set_frame(2, 2);
      foreach (gains[i]) begin
         write_reg(rhpf_pkg::CSR_STRENGTH_TENTHS, rhpf_pkg::CSR_DATA_W'(gains[i]));
         send_pixels(4);
         flush_frame();
         wait_quiet();
      end
   endtask

   task automatic test_frame_abandon();
      pick_idling();
      write_reg(rhpf_pkg::CSR_STRENGTH_TENTHS, rhpf_pkg::CSR_DATA_W'(8'd17));
      set_frame(4, 3);
      send_pixels(6);
      wait_quiet();
      // unknown index leaves the frame running
      write_reg(CSR_UNUSED_INDEX, rhpf_pkg::CSR_DATA_W'($urandom));
      send_pixels(6);
      flush_frame();
      wait_quiet();
      send_pixels(7);
      wait_quiet();
      write_reg(rhpf_pkg::CSR_IMAGE_WIDTH, rhpf_pkg::CSR_DATA_W'(5));
      send_pixels(8);
      wait_quiet();
      write_reg(rhpf_pkg::CSR_IMAGE_HEIGHT, rhpf_pkg::CSR_DATA_W'(2));
      send_pixels(10);
      flush_frame();
      wait_quiet();
   endtask

   task automatic test_size_clamps();
      pick_idling();
      set_frame(0, 1);
      send_pixels(4);
      flush_frame();
      wait_quiet();
      set_frame(1, 0);
      send_pixels(4);
      flush_frame();
      wait_quiet();
   endtask

   // start of each largest frame only, the next size write drops it
   task automatic test_largest_frames();
      int unsigned sizes [4][2];
      sizes = '{'{2048, 2}, '{4095, 2}, '{2, 4096}, '{2, 8191}};
      req_gap_max = 2;
      rsp_gap_max = 2;
      foreach (sizes[i]) begin
         write_reg(rhpf_pkg::CSR_STRENGTH_TENTHS,
                   rhpf_pkg::CSR_DATA_W'($urandom_range(0, 255)));
         set_frame(sizes[i][0], sizes[i][1]);
         send_pixels(LARGE_FRAME_WORDS);
         wait_quiet();
      end
   endtask

   task automatic test_random_frames();
      int unsigned start_count, w, h;
      start_count = words_taken;
      while (words_taken - start_count < RANDOM_WORDS) begin
         pick_idling();
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(2, 8);
         h = $urandom_range(2, 6);
         case ($urandom_range(0, 5))
            0: write_reg(rhpf_pkg::CSR_STRENGTH_TENTHS, rhpf_pkg::CSR_DATA_W'(8'd0));
            1: write_reg(rhpf_pkg::CSR_STRENGTH_TENTHS, rhpf_pkg::CSR_DATA_W'(8'd255));
            2: write_reg(rhpf_pkg::CSR_STRENGTH_TENTHS, rhpf_pkg::CSR_DATA_W'(8'd10));
            3: ;
            default: write_reg(rhpf_pkg::CSR_STRENGTH_TENTHS,
                               rhpf_pkg::CSR_DATA_W'($urandom_range(0, 255)));
         endcase
         if ($urandom_range(0, 7) == 0) begin
            write_reg(CSR_UNUSED_INDEX, rhpf_pkg::CSR_DATA_W'($urandom));
         end
         set_frame(w, h);
         if ($urandom_range(0, 5) == 0) begin
            // broken frame, the next size write drops it
            send_pixels($urandom_range(1, w * h - 1));
         end else begin
            send_pixels(w * h);
            flush_frame();
         end
         wait_quiet();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_PIXEL;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      csr_write_enable = 1'b0;
      csr_index = rhpf_pkg::CSR_IMAGE_WIDTH;
      csr_data = '0;
      cfg_width = rhpf_pkg::RESET_WIDTH;
      cfg_height = rhpf_pkg::RESET_HEIGHT;
      cfg_strength = rhpf_pkg::RESET_STRENGTH;
      for (int i = 0; i < MAX_W; i++) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
      restart_frame_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_kernel_extremes();
      test_strength_extremes();
      test_frame_abandon();
      test_size_clamps();
      test_random_frames();
      test_largest_frames();

      req_valid <= 1'b0;
      for (int n = 0; n < 50000 && expected_pixels.size() > 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() > 0) begin
         $error("%0d expected result words never arrived", expected_pixels.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== rgb_high_pass_3x3_filter_core.f =====
rtl/rhpf_pkg.sv
rtl/rhpf_line_store.sv
rtl/rhpf_window.sv
rtl/rhpf_scale.sv
rtl/rgb_high_pass_3x3_filter_core.sv
verif/rgb_high_pass_3x3_filter_core_tb.sv
